// File: rtl/core/pose_to_view_matrix_assert.svh
// assertion macros for the pose to view matrix block
// used by the checker; expects clk and rst_n in the enclosing scope
`ifndef POSE_TO_VIEW_MATRIX_ASSERT_SVH
`define POSE_TO_VIEW_MATRIX_ASSERT_SVH

// same-cycle implication
`define PTVM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pose_to_view_matrix check failed");

// next-cycle implication
`define PTVM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pose_to_view_matrix check failed");

`endif

// File: rtl/core/ptvm_pkg.sv
// shared types, widths and rounding helpers for the pose to view matrix block
// no dependencies
package ptvm_pkg;

    localparam int RotW      = 16;                  // Q2.14 entry
    localparam int PosW      = 32;                  // Q16.16 position
    localparam int PsumW     = PosW + 1;            // exact position + offset
    localparam int QprodW    = 2 * RotW;            // Q4.28 product
    localparam int RotAccW   = QprodW + 3;          // Q7.28 entry before rounding
    localparam int TprodW    = RotW + PsumW;        // Q19.30 product
    localparam int TsumW     = TprodW + 2;          // sum of three products
    localparam int TnegW     = TsumW + 1;           // negated sum
    localparam int FracDrop  = 14;                  // Q28 -> Q14, Q30 -> Q16

    typedef logic signed [RotW-1:0]    rot_t;
    typedef logic signed [PosW-1:0]    pos_t;
    typedef logic signed [PsumW-1:0]   psum_t;
    typedef logic signed [QprodW-1:0]  qprod_t;
    typedef logic signed [RotAccW-1:0] rot_acc_t;
    typedef logic signed [TprodW-1:0]  tprod_t;
    typedef logic signed [TsumW-1:0]   tsum_t;

    // stage load enables handed to the translation lanes
    typedef struct packed {
        logic load_prod;
        logic load_out;
    } ptvm_lane_ctl_t;

    localparam rot_acc_t OneQ28   = rot_acc_t'(1) <<< 28;
    localparam rot_acc_t RotHalf  = rot_acc_t'(1) <<< (FracDrop - 1);

    // round half up to Q2.14 and clamp to 16 bits
    function automatic rot_t rot_round_sat(input rot_acc_t v);
        rot_acc_t                           r;
        logic signed [RotAccW-FracDrop-1:0] sh;
        rot_t                               res;
        r  = v + RotHalf;
        sh = r[RotAccW-1:FracDrop];
        if (sh[RotAccW-FracDrop-1] && !(&sh[RotAccW-FracDrop-1:RotW-1]))
            res = {1'b1, {(RotW-1){1'b0}}};
        else if (!sh[RotAccW-FracDrop-1] && (|sh[RotAccW-FracDrop-1:RotW-1]))
            res = {1'b0, {(RotW-1){1'b1}}};
        else
            res = sh[RotW-1:0];
        return res;
    endfunction

    // negate, round half up to Q16.16 and clamp to 32 bits
    function automatic pos_t trans_round_sat(input tsum_t s);
        logic signed [TnegW-1:0]          n;
        logic signed [TnegW-FracDrop-1:0] sh;
        pos_t                             res;
        n  = -(TnegW'(s)) + (TnegW'(1) <<< (FracDrop - 1));
        sh = n[TnegW-1:FracDrop];
        if (sh[TnegW-FracDrop-1] && !(&sh[TnegW-FracDrop-1:PosW-1]))
            res = {1'b1, {(PosW-1){1'b0}}};
        else if (!sh[TnegW-FracDrop-1] && (|sh[TnegW-FracDrop-1:PosW-1]))
            res = {1'b0, {(PosW-1){1'b1}}};
        else
            res = sh[PosW-1:0];
        return res;
    endfunction

endpackage

// File: rtl/core/ptvm_if.sv
// valid/ready channel interfaces for pose input and matrix output
// no dependencies
interface ptvm_pose_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w,
        output pos_x, pos_y, pos_z, offset_x, offset_y, offset_z,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w,
        input  pos_x, pos_y, pos_z, offset_x, offset_y, offset_z,
        output ready
    );
endinterface

interface ptvm_mat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mat_0;
    logic signed [15:0] mat_1;
    logic signed [15:0] mat_2;
    logic signed [15:0] mat_4;
    logic signed [15:0] mat_5;
    logic signed [15:0] mat_6;
    logic signed [15:0] mat_8;
    logic signed [15:0] mat_9;
    logic signed [15:0] mat_10;
    logic signed [31:0] mat_12;
    logic signed [31:0] mat_13;
    logic signed [31:0] mat_14;

    modport source (
        output valid, mat_0, mat_1, mat_2, mat_4, mat_5, mat_6,
        output mat_8, mat_9, mat_10, mat_12, mat_13, mat_14,
        input  ready
    );
    modport sink (
        input  valid, mat_0, mat_1, mat_2, mat_4, mat_5, mat_6,
        input  mat_8, mat_9, mat_10, mat_12, mat_13, mat_14,
        output ready
    );
endinterface

// File: rtl/core/ptvm_dot3.sv
// one translation lane: three rotation-by-position products, then negated rounded sum
// depends on ptvm_pkg
module ptvm_dot3
    import ptvm_pkg::*;
(
    input  logic           clk,
    input  ptvm_lane_ctl_t ctl,
    input  rot_t           row [3],
    input  psum_t          pnt [3],
    output pos_t           trans
);

    tprod_t prod_reg [3];
    pos_t   trans_reg;
    pos_t   trans_next;
    tsum_t  sum;

    // products: 16 x 33 signed, one per multiplier
    always_ff @(posedge clk)
    begin
        if (ctl.load_prod)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= row[i] * pnt[i];
            end
        end
    end

    always_comb
    begin
        sum        = TsumW'(prod_reg[0]) + TsumW'(prod_reg[1]) + TsumW'(prod_reg[2]);
        trans_next = trans_round_sat(sum);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            trans_reg <= trans_next;
        end
    end

    assign trans = trans_reg;

endmodule

// File: rtl/core/pose_to_view_matrix.sv
// top level of the pose to view matrix block: four-stage pipeline
// depends on ptvm_pkg, ptvm_if.sv and ptvm_dot3
//
//   channel | modport | direction | payload
//   --------+---------+-----------+------------------------------------------
//   pose    | sink    | in        | quat_x..quat_w, pos_x..pos_z, offset_x..z
//   mat     | source  | out       | mat_0..mat_10 (rotation), mat_12..mat_14
//
// a pose transfer may happen every cycle unless a stall on mat drops pose.ready
// stages: quaternion products and position sums, rotation entries with
// rounding, rotation-by-position multiplies, negated sum with rounding
// the stage boundaries are set by the 16 x 33 multiplies of the translation
// every stage has its own valid bit and moves when the stage after it is
// free, so a stall on mat fills the empty stages before pose.ready drops
// rst_n clears only the valid bits; payload registers are not reset
module pose_to_view_matrix
    import ptvm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ptvm_pose_if.sink  pose,
    ptvm_mat_if.source mat
);

    // ------------------------------------------------------------------
    // handshake: a stage loads when it is empty or its content moves on
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next;
    logic s1_free, s2_free, s3_free, s4_free;

    assign s4_free = !s4_valid_reg || mat.ready;
    assign s3_free = !s3_valid_reg || s4_free;
    assign s2_free = !s2_valid_reg || s3_free;
    assign s1_free = !s1_valid_reg || s2_free;

    assign pose.ready = s1_free;

    always_comb
    begin
        s1_valid_next = s1_free ? pose.valid   : s1_valid_reg;
        s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_free ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = s4_free ? s3_valid_reg : s4_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: quaternion products (Q4.28) and position + offset (33 bits)
    // ------------------------------------------------------------------
    qprod_t xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    psum_t  s1_p_reg [3];

    always_ff @(posedge clk)
    begin
        if (s1_free && pose.valid)
        begin
            xx_reg      <= pose.quat_x * pose.quat_x;
            yy_reg      <= pose.quat_y * pose.quat_y;
            zz_reg      <= pose.quat_z * pose.quat_z;
            xy_reg      <= pose.quat_x * pose.quat_y;
            xz_reg      <= pose.quat_x * pose.quat_z;
            yz_reg      <= pose.quat_y * pose.quat_z;
            xw_reg      <= pose.quat_x * pose.quat_w;
            yw_reg      <= pose.quat_y * pose.quat_w;
            zw_reg      <= pose.quat_z * pose.quat_w;
            s1_p_reg[0] <= PsumW'(pose.pos_x) + PsumW'(pose.offset_x);
            s1_p_reg[1] <= PsumW'(pose.pos_y) + PsumW'(pose.offset_y);
            s1_p_reg[2] <= PsumW'(pose.pos_z) + PsumW'(pose.offset_z);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: rotation entries, rounded and clamped to Q2.14
    // ------------------------------------------------------------------
    // 1 - 2(a + b)
    function automatic rot_acc_t diag_q28(input qprod_t a, input qprod_t b);
        return OneQ28 - ((RotAccW'(a) + RotAccW'(b)) <<< 1);
    endfunction

    // 2(a + b) or 2(a - b)
    function automatic rot_acc_t cross_q28(input qprod_t a, input qprod_t b,
                                           input logic sub);
        rot_acc_t s;
        s = sub ? (RotAccW'(a) - RotAccW'(b)) : (RotAccW'(a) + RotAccW'(b));
        return s <<< 1;
    endfunction

    rot_t  m_next [9];
    rot_t  s2_m_reg [9];
    psum_t s2_p_reg [3];

    // entry order: mat_0, 1, 2, 4, 5, 6, 8, 9, 10
    always_comb
    begin
        m_next[0] = rot_round_sat(diag_q28(yy_reg, zz_reg));
        m_next[1] = rot_round_sat(cross_q28(xy_reg, zw_reg, 1'b1));
        m_next[2] = rot_round_sat(cross_q28(xz_reg, yw_reg, 1'b0));
        m_next[3] = rot_round_sat(cross_q28(xy_reg, zw_reg, 1'b0));
        m_next[4] = rot_round_sat(diag_q28(xx_reg, zz_reg));
        m_next[5] = rot_round_sat(cross_q28(yz_reg, xw_reg, 1'b1));
        m_next[6] = rot_round_sat(cross_q28(xz_reg, yw_reg, 1'b1));
        m_next[7] = rot_round_sat(cross_q28(yz_reg, xw_reg, 1'b0));
        m_next[8] = rot_round_sat(diag_q28(xx_reg, yy_reg));
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_m_reg <= m_next;
            s2_p_reg <= s1_p_reg;
        end
    end

    // ------------------------------------------------------------------
    // stages 3 and 4: rotation entries ride along while the lanes work
    // ------------------------------------------------------------------
    rot_t           s3_m_reg [9];
    rot_t           s4_m_reg [9];
    ptvm_lane_ctl_t lane_ctl;

    assign lane_ctl.load_prod = s3_free && s2_valid_reg;
    assign lane_ctl.load_out  = s4_free && s3_valid_reg;

    always_ff @(posedge clk)
    begin
        if (lane_ctl.load_prod)
        begin
            s3_m_reg <= s2_m_reg;
        end
        if (lane_ctl.load_out)
        begin
            s4_m_reg <= s3_m_reg;
        end
    end

    // transposed rotation rows: each translation uses one matrix column
    rot_t row_x [3];
    rot_t row_y [3];
    rot_t row_z [3];
    pos_t trans_x, trans_y, trans_z;

    assign row_x[0] = s2_m_reg[0];
    assign row_x[1] = s2_m_reg[3];
    assign row_x[2] = s2_m_reg[6];
    assign row_y[0] = s2_m_reg[1];
    assign row_y[1] = s2_m_reg[4];
    assign row_y[2] = s2_m_reg[7];
    assign row_z[0] = s2_m_reg[2];
    assign row_z[1] = s2_m_reg[5];
    assign row_z[2] = s2_m_reg[8];

    ptvm_dot3 u_lane_x (.clk(clk), .ctl(lane_ctl), .row(row_x), .pnt(s2_p_reg), .trans(trans_x));
    ptvm_dot3 u_lane_y (.clk(clk), .ctl(lane_ctl), .row(row_y), .pnt(s2_p_reg), .trans(trans_y));
    ptvm_dot3 u_lane_z (.clk(clk), .ctl(lane_ctl), .row(row_z), .pnt(s2_p_reg), .trans(trans_z));

    // ------------------------------------------------------------------
    // output transfer
    // ------------------------------------------------------------------
    assign mat.valid  = s4_valid_reg;
    assign mat.mat_0  = s4_m_reg[0];
    assign mat.mat_1  = s4_m_reg[1];
    assign mat.mat_2  = s4_m_reg[2];
    assign mat.mat_4  = s4_m_reg[3];
    assign mat.mat_5  = s4_m_reg[4];
    assign mat.mat_6  = s4_m_reg[5];
    assign mat.mat_8  = s4_m_reg[6];
    assign mat.mat_9  = s4_m_reg[7];
    assign mat.mat_10 = s4_m_reg[8];
    assign mat.mat_12 = trans_x;
    assign mat.mat_13 = trans_y;
    assign mat.mat_14 = trans_z;

endmodule

// File: rtl/core/ptvm_checker.sv
// port-level checks for pose_to_view_matrix, bound to the top level
// depends on pose_to_view_matrix_assert.svh
`include "pose_to_view_matrix_assert.svh"

module ptvm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] mat_0,
    input logic signed [15:0] mat_1,
    input logic signed [15:0] mat_2,
    input logic signed [15:0] mat_4,
    input logic signed [15:0] mat_5,
    input logic signed [15:0] mat_6,
    input logic signed [15:0] mat_8,
    input logic signed [15:0] mat_9,
    input logic signed [15:0] mat_10,
    input logic signed [31:0] mat_12,
    input logic signed [31:0] mat_13,
    input logic signed [31:0] mat_14
);

    logic [239:0] out_bits;

    assign out_bits = {mat_0, mat_1, mat_2, mat_4, mat_5, mat_6, mat_8, mat_9, mat_10,
                       mat_12, mat_13, mat_14};

    // a waiting result stays until its transfer
    `PTVM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // and its payload does not change meanwhile
    `PTVM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_bits))
    // with out_ready held high after a pose transfer, its result comes out valid
    `PTVM_ASSERT_NEXT(a_latency, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)
    // diagonal entries are one minus a sum of squares, never above one
    `PTVM_ASSERT_NOW(a_diag_bound, out_valid, mat_0 <= 16384 && mat_5 <= 16384 && mat_10 <= 16384)

endmodule

bind pose_to_view_matrix ptvm_checker u_ptvm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pose.valid),
    .in_ready  (pose.ready),
    .out_valid (mat.valid),
    .out_ready (mat.ready),
    .mat_0     (mat.mat_0),
    .mat_1     (mat.mat_1),
    .mat_2     (mat.mat_2),
    .mat_4     (mat.mat_4),
    .mat_5     (mat.mat_5),
    .mat_6     (mat.mat_6),
    .mat_8     (mat.mat_8),
    .mat_9     (mat.mat_9),
    .mat_10    (mat.mat_10),
    .mat_12    (mat.mat_12),
    .mat_13    (mat.mat_13),
    .mat_14    (mat.mat_14)
);
